### sv/ibp_pkg.sv
package ibp_pkg;

   localparam int SlotCount = 6;
   localparam int WordCount = 4;
   localparam int MaxJumps = 2;
   localparam int MaxConsts = 3;
   localparam logic [31:0] NopSlot = 32'd2;
   localparam logic [18:0] ExtMask = 19'h7ffff;

   typedef enum logic [2:0] {
      FUNC_REG_INT   = 3'd0,
      FUNC_CONST_INT = 3'd1,
      FUNC_COND_JUMP = 3'd2,
      FUNC_JUMP      = 3'd3,
      FUNC_NO_PARAM  = 3'd4,
      FUNC_FLUSH     = 3'd5
   } func_type;

   typedef enum logic [1:0] {
      KIND_IGNORE,
      KIND_PLACE,
      KIND_FLUSH
   } item_kind_type;

   typedef struct packed {
      logic [2:0]  func;
      logic [10:0] opcode;
      logic [4:0]  reg_a;
      logic [4:0]  reg_b;
      logic [4:0]  reg_t;
      logic [31:0] constant;
   } req_item_type;

   typedef struct packed {
      item_kind_type kind;
      logic [31:0]   slot;
      logic          is_jump;
      logic          needs_ext;
      logic [18:0]   upper;
   } slot_info_type;

   typedef struct packed {
      logic                         load;
      logic [WordCount-1:0][63:0]   words;
   } bundle_type;

endpackage

### sv/ibp_if.sv
interface ibp_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [10:0] opcode;
   logic [4:0]  reg_a;
   logic [4:0]  reg_b;
   logic [4:0]  reg_t;
   logic [31:0] constant;

   modport source (output valid, func, opcode, reg_a, reg_b, reg_t, constant, input ready);
   modport sink (input valid, func, opcode, reg_a, reg_b, reg_t, constant, output ready);
endinterface

interface ibp_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] bundle_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source (output valid, bundle_word, word_index, last_word, input ready);
   modport sink (input valid, bundle_word, word_index, last_word, output ready);
endinterface

### sv/ibp_slot_encoder.sv
module ibp_slot_encoder (
   input  ibp_pkg::req_item_type  item,
   output ibp_pkg::slot_info_type info
);
   import ibp_pkg::*;

   always_comb begin
      logic [18:0] upper;
      upper = item.constant[31:13];
      info.kind = KIND_PLACE;
      info.slot = '0;
      info.is_jump = 1'b0;
      info.needs_ext = 1'b0;
      info.upper = upper;
      unique case (func_type'(item.func))
         FUNC_REG_INT: begin
            info.slot = 32'({item.opcode[5:0], item.reg_t, item.reg_b, item.reg_a, 9'b0});
         end
         FUNC_CONST_INT: begin
            info.slot = {item.constant[12:0], item.reg_t, item.reg_a, 3'b001,
                         item.opcode[5:0]};
            info.needs_ext = (upper != '0) && (upper != ExtMask);
         end
         FUNC_COND_JUMP: begin
            info.slot = 32'({item.opcode[1:0], 6'b0, 1'b1, item.opcode[3:2]});
            info.is_jump = 1'b1;
         end
         FUNC_JUMP: begin
            info.slot = 32'(item.opcode);
            info.is_jump = 1'b1;
         end
         FUNC_NO_PARAM: begin
            info.slot = 32'(item.opcode[8:0]);
         end
         FUNC_FLUSH: begin
            info.kind = KIND_FLUSH;
         end
         default: begin
            info.kind = KIND_IGNORE;
         end
      endcase
   end

endmodule

### sv/ibp_bundle_state.sv
module ibp_bundle_state (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  ibp_pkg::slot_info_type info,
   input  logic                   drain_free,
   output logic                   advance,
   output ibp_pkg::bundle_type    bundle
);
   import ibp_pkg::*;

   logic [SlotCount-1:0][31:0] store_ff;
   logic [SlotCount-1:0][31:0] store_in;
   logic [63:0]                tail_ff, tail_in;
   logic [2:0]                 slots_ff, slots_in;
   logic [1:0]                 consts_ff, consts_in;
   logic [1:0]                 jumps_ff, jumps_in;
   logic                       emit_need;
   logic                       emit;

   always_comb begin
      emit_need = 1'b0;
      unique case (info.kind)
         KIND_FLUSH: emit_need = slots_ff != '0;
         KIND_PLACE: emit_need = (slots_ff >= 3'(SlotCount))
                              || (info.is_jump && jumps_ff >= 2'(MaxJumps))
                              || (info.needs_ext && consts_ff == 2'(MaxConsts));
         default:    emit_need = 1'b0;
      endcase
      advance = item_valid && (!emit_need || drain_free);
      emit = advance && emit_need;
   end

   always_comb begin
      logic [2:0]  base_slots;
      logic [1:0]  base_consts;
      logic [1:0]  base_jumps;
      logic [63:0] base_tail;
      base_slots = emit ? '0 : slots_ff;
      base_consts = emit ? '0 : consts_ff;
      base_jumps = emit ? '0 : jumps_ff;
      base_tail = emit ? '0 : tail_ff;
      slots_in = base_slots;
      consts_in = base_consts;
      jumps_in = base_jumps;
      tail_in = base_tail;
      store_in = store_ff;
      if (advance && info.kind == KIND_PLACE) begin
         slots_in = base_slots + 3'd1;
         jumps_in = base_jumps + 2'(info.is_jump);
         for (int i = 0; i < SlotCount; i++) begin
            if (base_slots == 3'(i)) begin
               store_in[i] = info.slot;
            end
         end
         if (info.needs_ext) begin
            consts_in = base_consts + 2'd1;
            unique case (base_consts)
               2'd0:    tail_in[25:7] = info.upper;
               2'd1:    tail_in[44:26] = info.upper;
               2'd2:    tail_in[63:45] = info.upper;
               default: tail_in = base_tail;
            endcase
            tail_in[base_slots] = 1'b1;
         end
      end
   end

   always_comb begin
      logic [SlotCount-1:0][31:0] s;
      for (int i = 0; i < SlotCount; i++) begin
         s[i] = (3'(i) < slots_ff) ? store_ff[i] : NopSlot;
      end
      bundle.load = emit;
      for (int w = 0; w < WordCount - 1; w++) begin
         bundle.words[w] = {s[2*w+1], s[2*w]};
      end
      bundle.words[WordCount-1] = tail_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff <= '0;
         slots_ff <= '0;
         consts_ff <= '0;
         jumps_ff <= '0;
      end else begin
         tail_ff <= tail_in;
         slots_ff <= slots_in;
         consts_ff <= consts_in;
         jumps_ff <= jumps_in;
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

### sv/ibp_drain.sv
module ibp_drain (
   input  logic                clock,
   input  logic                reset,
   input  ibp_pkg::bundle_type bundle,
   output logic                free,
   ibp_rsp_if.source           rsp
);
   import ibp_pkg::*;

   logic [WordCount-1:0][63:0] words_ff;
   logic                       vld_ff, vld_in;
   logic [1:0]                 cnt_ff, cnt_in;
   logic                       beat;
   logic                       last;

   always_comb begin
      beat = vld_ff && rsp.ready;
      last = cnt_ff == 2'(WordCount - 1);
      free = !vld_ff || (rsp.ready && last);
      cnt_in = beat ? cnt_ff + 2'd1 : cnt_ff;
      priority if (bundle.load) begin
         vld_in = 1'b1;
      end else if (beat && last) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (bundle.load) begin
         words_ff <= bundle.words;
      end
   end

   assign rsp.valid = vld_ff;
   assign rsp.bundle_word = words_ff[cnt_ff];
   assign rsp.word_index = cnt_ff;
   assign rsp.last_word = last;

endmodule

### sv/instruction_bundle_packer.sv
// Instruction bundle packer.
// The req_bus channel takes one instruction request per beat: func, opcode, register
// numbers and a 32-bit constant. Each request is encoded into a 32-bit slot and
// collected in a bundle of six slots plus a 64-bit constant tail. When a request
// finds no room, or on a flush, the bundle goes out on rsp_bus as four 64-bit
// beats: slots 1:0, 3:2, 5:4 and then the tail, with word_index 0..3 and
// last_word on the fourth beat. Unused slots read as the nop value 2.
// A request is registered at acceptance and processed from the input register;
// the bundle that it closes is loaded into the output buffer, which then offers
// the first beat. One request is accepted every cycle but for this wait: a
// request that closes a bundle waits in the input register while the previous
// bundle still has beats to deliver, since the output buffer holds one bundle.
// Stalls on rsp_bus hold the input back only in that case.
// Reset is synchronous and empties the input register, the bundle and the
// output buffer.
module instruction_bundle_packer (
   input  logic      clock,
   input  logic      reset,
   ibp_req_if.sink   req_bus,
   ibp_rsp_if.source rsp_bus
);
   import ibp_pkg::*;

   logic          in_vld_ff, in_vld_in;
   req_item_type  in_item_ff;
   logic          accept;
   logic          advance;
   logic          drain_free;
   slot_info_type info;
   bundle_type    bundle;

   assign req_bus.ready = !in_vld_ff || advance;
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      priority if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end else begin
         in_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff <= '{func: req_bus.func, opcode: req_bus.opcode, reg_a: req_bus.reg_a,
                         reg_b: req_bus.reg_b, reg_t: req_bus.reg_t,
                         constant: req_bus.constant};
      end
   end

   ibp_slot_encoder u_encoder (
      .item (in_item_ff),
      .info (info)
   );

   ibp_bundle_state u_state (
      .clock      (clock),
      .reset      (reset),
      .item_valid (in_vld_ff),
      .info       (info),
      .drain_free (drain_free),
      .advance    (advance),
      .bundle     (bundle)
   );

   ibp_drain u_drain (
      .clock  (clock),
      .reset  (reset),
      .bundle (bundle),
      .free   (drain_free),
      .rsp    (rsp_bus)
   );

`ifndef NO_ASSERTIONS
   a_stall_only_on_drain: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (in_vld_ff && rsp_bus.valid))
      else $error("input stalled while no bundle was draining");

   a_held_item_stable: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> (in_vld_ff && $stable(in_item_ff)))
      else $error("held request lost or changed");

   a_bundle_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> (rsp_bus.word_index == 2'd0))
      else $error("bundle did not start with word zero");

   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_word) |=>
      (rsp_bus.valid && rsp_bus.word_index == $past(rsp_bus.word_index) + 2'd1))
      else $error("bundle beats out of sequence");
`endif

endmodule
